// ===== design/cpc_pkg.sv =====
package cpc_pkg;
  localparam int PacketWords = 22;
  localparam int SumWords = 19;
  localparam int IdxW = 5;
  localparam logic [15:0] HeaderWord = 16'h000A;
  localparam logic [IdxW-1:0] CheckIndex = 5'd21;
  localparam logic [14:0] ScaleReset = 15'h7FFF;
  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusBadHeader = 2'd1;
  localparam logic [1:0] StatusBadSum = 2'd2;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] computed;
    logic [15:0] received;
    logic [15:0] w1;
    logic [15:0] w2;
    logic [15:0] w3;
    logic [15:0] w4;
    logic [15:0] w5;
    logic [15:0] w6;
  } job_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] ref_a;
    logic [15:0] ref_b;
    logic [15:0] lim_a;
    logic [15:0] lim_b;
    logic [14:0] gain_a;
    logic [14:0] gain_b;
    logic [15:0] computed;
    logic [15:0] received;
    logic [15:0] bad_count;
    logic        resync;
  } result_t;
endpackage

// ===== design/command_packet_checker_decoder.sv =====
// Flow: a rejected packet goes from the end word through the front-end
// classify register and the back end's done state to its result; an accepted
// packet is taken, passes four serial divides (load, divide, store), then is handed off.
// Throughput: one word per cycle while a packet streams; input stalls for the
// cycle after an end word and while a decoded packet waits for the back end.
// Reset (rst, synchronous): clear position, sum, count, outputs, scale 32767.
module command_packet_checker_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [15:0] word,
  input  logic        end_of_packet,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic [15:0] current_ref_a,
  output logic [15:0] current_ref_b,
  output logic [15:0] current_limit_a,
  output logic [15:0] current_limit_b,
  output logic [14:0] gain_a,
  output logic [14:0] gain_b,
  output logic [15:0] computed_sum,
  output logic [15:0] received_sum,
  output logic [15:0] bad_count,
  output logic        resync,
  input  logic        cfg_we,
  input  logic [14:0] cfg_data
);
  logic [14:0] current_scale;
  logic job_valid, job_ready, res_valid;
  cpc_pkg::job_t job;
  cpc_pkg::result_t res;
  // hold a decoded packet while the back end is busy
  logic q_valid;
  cpc_pkg::job_t q_job;

  always_ff @(posedge clk) begin
    if (rst) current_scale <= cpc_pkg::ScaleReset;
    else if (cfg_we) current_scale <= cfg_data;
  end

  // stall input while a finished packet waits for the back end
  assign full = q_valid || job_valid;

  always_ff @(posedge clk) begin
    if (rst) q_valid <= 1'b0;
    else if (job_valid && !job_ready) begin
      q_valid <= 1'b1;
      q_job <= job;
    end else if (q_valid && job_ready) q_valid <= 1'b0;
  end

  cpc_front u_front (
    .clk(clk), .rst(rst), .word(word), .end_of_packet(end_of_packet),
    .take(push && !full), .job_valid(job_valid), .job(job)
  );

  cpc_back u_back (
    .clk(clk), .rst(rst), .current_scale(current_scale),
    .job_valid(q_valid || job_valid), .job(q_valid ? q_job : job),
    .job_ready(job_ready), .res_valid(res_valid), .res(res),
    .res_take(pop)
  );

  assign empty = !res_valid;
  assign status = res.status;
  assign current_ref_a = res.ref_a;
  assign current_ref_b = res.ref_b;
  assign current_limit_a = res.lim_a;
  assign current_limit_b = res.lim_b;
  assign gain_a = res.gain_a;
  assign gain_b = res.gain_b;
  assign computed_sum = res.computed;
  assign received_sum = res.received;
  assign bad_count = res.bad_count;
  assign resync = res.resync;
endmodule

// ===== design/cpc_front.sv =====
module cpc_front (
  input  logic            clk,
  input  logic            rst,
  input  logic [15:0]     word,
  input  logic            end_of_packet,
  input  logic            take,
  output logic            job_valid,
  output cpc_pkg::job_t   job
);
  logic [cpc_pkg::IdxW-1:0] word_index;
  logic [15:0] running_sum;
  logic        header_seen;
  logic [15:0] cap [1:6];
  logic [15:0] check_word;
  logic [16:0] sum_wide;
  logic [15:0] sum_next;
  logic        hdr_next;
  logic        in_pkt;

  assign in_pkt = word_index < cpc_pkg::IdxW'(cpc_pkg::PacketWords);
  assign sum_wide = {1'b0, running_sum} + {1'b0, word};
  assign sum_next = (in_pkt && word_index < cpc_pkg::IdxW'(cpc_pkg::SumWords)) ?
                    sum_wide[15:0] + {15'd0, sum_wide[16]} : running_sum;
  assign hdr_next = (word_index == '0) ? (word == cpc_pkg::HeaderWord) : header_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_index <= '0;
      running_sum <= '0;
      header_seen <= 1'b0;
      check_word <= '0;
      job_valid <= 1'b0;
    end else begin
      job_valid <= take && end_of_packet;
      if (take) begin
        if (in_pkt) begin
          // capture words 1..6 and the check word
          for (int i = 1; i <= 6; i++) begin
            if (word_index == cpc_pkg::IdxW'(i)) cap[i] <= word;
          end
          if (word_index == cpc_pkg::CheckIndex) check_word <= word;
        end
        if (end_of_packet) begin
          word_index <= '0;
          running_sum <= '0;
          header_seen <= 1'b0;
        end else begin
          if (in_pkt) word_index <= word_index + 1'b1;
          running_sum <= sum_next;
          header_seen <= hdr_next;
        end
      end
    end
  end

  // classify from the registered capture in the cycle after the end word
  logic [15:0] chk_r;
  logic [15:0] sum_r;
  logic        hdr_r;
  always_ff @(posedge clk) begin
    if (take && end_of_packet) begin
      sum_r <= sum_next;
      hdr_r <= hdr_next;
      chk_r <= (in_pkt && word_index == cpc_pkg::CheckIndex) ? word : check_word;
    end
  end

  always_comb begin
    job.w1 = cap[1]; job.w2 = cap[2]; job.w3 = cap[3];
    job.w4 = cap[4]; job.w5 = cap[5]; job.w6 = cap[6];
    if (!hdr_r) begin
      job.status = cpc_pkg::StatusBadHeader;
      job.computed = '0;
      job.received = '0;
    end else begin
      job.computed = ~sum_r;
      job.received = chk_r;
      job.status = (~sum_r == chk_r) ? cpc_pkg::StatusOk : cpc_pkg::StatusBadSum;
    end
  end
endmodule

// ===== design/cpc_back.sv =====
module cpc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic [14:0]       current_scale,
  input  logic              job_valid,
  input  cpc_pkg::job_t     job,
  output logic              job_ready,
  output logic              res_valid,
  output cpc_pkg::result_t  res,
  input  logic              res_take
);
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SLoad = 3'd1;
  localparam logic [2:0] SDiv = 3'd2;
  localparam logic [2:0] SStore = 3'd3;
  localparam logic [2:0] SDone = 3'd4;

  logic [2:0]  state;
  logic [1:0]  sel;
  logic [4:0]  bitn;
  logic [15:0] acc [0:5];
  logic [15:0] bad_count;
  cpc_pkg::job_t jr;
  logic [30:0] rem;
  logic [31:0] quo;
  logic [31:0] mag;
  logic        neg;
  logic        num_zero;
  logic [15:0] raw;
  logic [15:0] raw_mag;
  logic [15:0] sat;
  logic [31:0] trial;
  logic [31:0] scale_w;

  // take a new packet only once the previous result has been popped
  assign job_ready = (state == SIdle) && !res_valid;

  always_comb begin
    case (sel)
      2'd0: raw = jr.w1;
      2'd1: raw = jr.w2;
      2'd2: raw = 16'(jr.w3 * 16'd100);
      default: raw = 16'(jr.w4 * 16'd100);
    endcase
  end

  assign raw_mag = raw[15] ? 16'(-raw) : raw;
  assign trial = {rem, mag[31]};
  assign scale_w = {17'd0, current_scale};

  always_comb begin
    if (current_scale == '0)
      sat = neg ? 16'h8000 : (num_zero ? 16'h0000 : 16'h7FFF);
    else if (!neg)
      sat = (quo > 32'd32767) ? 16'h7FFF : quo[15:0];
    else
      sat = (quo > 32'd32768) ? 16'h8000 : 16'(~quo + 32'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
      bad_count <= '0;
      res_valid <= 1'b0;
      for (int i = 0; i < 6; i++) acc[i] <= '0;
    end else begin
      if (res_valid && res_take) res_valid <= 1'b0;
      case (state)
        SIdle: begin
          if (job_valid && !res_valid) begin
            jr <= job;
            if (job.status == cpc_pkg::StatusOk) begin
              sel <= 2'd0;
              state <= SLoad;
            end else begin
              bad_count <= bad_count + 16'd1;
              state <= SDone;
            end
          end
        end
        SLoad: begin
          // numerator magnitude times 2^15
          neg <= raw[15];
          num_zero <= (raw == '0);
          mag <= {1'b0, raw_mag, 15'd0};
          rem <= '0;
          quo <= '0;
          bitn <= 5'd0;
          state <= SDiv;
        end
        SDiv: begin
          // one restoring step per cycle, 32 steps per value
          if (trial >= scale_w) begin
            rem <= 31'(trial - scale_w);
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= trial[30:0];
            quo <= {quo[30:0], 1'b0};
          end
          mag <= {mag[30:0], 1'b0};
          bitn <= bitn + 5'd1;
          if (bitn == 5'd31) state <= SStore;
        end
        SStore: begin
          acc[{1'b0, sel}] <= sat;
          if (sel == 2'd3) begin
            acc[4] <= (jr.w5 < 16'd32767) ? jr.w5 : '0;
            acc[5] <= (jr.w6 < 16'd32767) ? jr.w6 : '0;
            state <= SDone;
          end else begin
            sel <= sel + 2'd1;
            state <= SLoad;
          end
        end
        SDone: begin
          res_valid <= 1'b1;
          state <= SIdle;
        end
        default: state <= SIdle;
      endcase
    end
  end

  always_comb begin
    res.status = jr.status;
    res.ref_a = acc[0];
    res.ref_b = acc[1];
    res.lim_a = acc[2];
    res.lim_b = acc[3];
    res.gain_a = acc[4][14:0];
    res.gain_b = acc[5][14:0];
    res.computed = jr.computed;
    res.received = jr.received;
    res.bad_count = bad_count;
    res.resync = jr.status == cpc_pkg::StatusBadHeader;
  end
endmodule
